// File: sv/rbs_pkg.sv
`default_nettype none
package rbs_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int NUM_AXES        = 3;
   localparam int NUM_LANES       = 2 * NUM_AXES;
   localparam int CSR_IDX_WIDTH   = 3;

   // configuration register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_MIN_X = 3'd0,
      CSR_MIN_Y = 3'd1,
      CSR_MIN_Z = 3'd2,
      CSR_MAX_X = 3'd3,
      CSR_MAX_Y = 3'd4,
      CSR_MAX_Z = 3'd5
   } csr_index_type;
endpackage
`default_nettype wire

// File: sv/rbs_req_if.sv
`default_nettype none
interface rbs_req_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] origin_x;
   logic signed [W-1:0] origin_y;
   logic signed [W-1:0] origin_z;
   logic signed [W-1:0] dir_x;
   logic signed [W-1:0] dir_y;
   logic signed [W-1:0] dir_z;
   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface
`default_nettype wire

// File: sv/rbs_rsp_if.sv
`default_nettype none
interface rbs_rsp_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic                hit_found;
   logic signed [W-1:0] t_enter;
   logic signed [W-1:0] t_exit;
   modport source (output valid, hit_found, t_enter, t_exit, input ready);
   modport sink (input valid, hit_found, t_enter, t_exit, output ready);
endinterface
`default_nettype wire

// File: sv/rbs_csr_if.sv
`default_nettype none
interface rbs_csr_if
   import rbs_pkg::*;
#(parameter int W = 32);
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_WIDTH-1:0] index;
   logic [W-1:0]             data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/rbs_box_regs.sv
`default_nettype none
module rbs_box_regs
   import rbs_pkg::*;
#(
   parameter int W = COORD_WIDTH_DEF,
   parameter int F = FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rbs_csr_if.sink          csr_ch,
   output logic signed [W-1:0] box_min [NUM_AXES],
   output logic signed [W-1:0] box_max [NUM_AXES]
);
   logic signed [W-1:0] min_ff [NUM_AXES];
   logic signed [W-1:0] max_ff [NUM_AXES];

   assign csr_ch.ready = 1'b1;

   // box corner registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            min_ff[a] <= '0;
            max_ff[a] <= W'(1) << F;
         end
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_MIN_X: min_ff[0] <= csr_ch.data;
            CSR_MIN_Y: min_ff[1] <= csr_ch.data;
            CSR_MIN_Z: min_ff[2] <= csr_ch.data;
            CSR_MAX_X: max_ff[0] <= csr_ch.data;
            CSR_MAX_Y: max_ff[1] <= csr_ch.data;
            CSR_MAX_Z: max_ff[2] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign box_min = min_ff;
   assign box_max = max_ff;
endmodule
`default_nettype wire

// File: sv/rbs_div_lane.sv
`default_nettype none
module rbs_div_lane
   import rbs_pkg::*;
#(
   parameter int W = COORD_WIDTH_DEF,
   parameter int F = FRAC_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic [W-1:0] en,
   input  wire logic [W:0]   n_in,
   input  wire logic [W-1:0] d_in,
   input  wire logic         neg_in,
   input  wire logic         ovf_in,
   output logic [W-1:0]      q_out,
   output logic              neg_out,
   output logic              ovf_out
);
   localparam int RW = W + 1 + F;
   localparam int CW = 2 * W + F + 1;

   logic [RW-1:0] r_ff   [W];
   logic [W-1:0]  q_ff   [W];
   logic [W-1:0]  d_ff   [W];
   logic          neg_ff [W];
   logic          ovf_ff [W];

   // one restoring step per stage, quotient bit W-1-j in stage j
   for (genvar j = 0; j < W; j++) begin : g_step
      logic [RW-1:0] r_prev;
      logic [W-1:0]  q_prev;
      logic [W-1:0]  d_prev;
      logic          neg_prev;
      logic          ovf_prev;
      logic [CW-1:0] dsh;
      logic [CW-1:0] rext;
      logic          ge;

      if (j == 0) begin : g_first
         assign r_prev   = RW'(n_in) << F;
         assign q_prev   = '0;
         assign d_prev   = d_in;
         assign neg_prev = neg_in;
         assign ovf_prev = ovf_in;
      end else begin : g_next
         assign r_prev   = r_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign d_prev   = d_ff[j-1];
         assign neg_prev = neg_ff[j-1];
         assign ovf_prev = ovf_ff[j-1];
      end

      assign dsh  = CW'(d_prev) << (W - 1 - j);
      assign rext = CW'(r_prev);
      assign ge   = rext >= dsh;

      always_ff @(posedge clock) begin
         if (en[j]) begin
            r_ff[j]   <= ge ? RW'(rext - dsh) : r_prev;
            q_ff[j]   <= q_prev | (ge ? (W'(1) << (W - 1 - j)) : '0);
            d_ff[j]   <= d_prev;
            neg_ff[j] <= neg_prev;
            ovf_ff[j] <= ovf_prev;
         end
      end
   end

   assign q_out   = q_ff[W-1];
   assign neg_out = neg_ff[W-1];
   assign ovf_out = ovf_ff[W-1];
endmodule
`default_nettype wire

// File: sv/ray_box_slab_intersect.sv
// request to response: stage A, stage B, the divider stages, stage C, stage D
// one ray per cycle when the response is not stalled; the six quotients run through
// one-bit-per-stage restoring divider pipelines, one stage per quotient bit
// a stalled response holds the pipeline back stage by stage, bubbles are squeezed out
// reset (synchronous) empties the pipeline and sets the box to min 0.0, max 1.0
`default_nettype none
module ray_box_slab_intersect
   import rbs_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   rbs_req_if.sink  req_ch,
   rbs_rsp_if.source rsp_ch,
   rbs_csr_if.sink  csr_ch
);
   localparam int W = COORD_WIDTH;
   localparam int F = FRAC_BITS;
   localparam int S = W + 4;
   localparam int ST_C = W + 2;
   localparam logic signed [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] TMIN = {1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0] box_min [NUM_AXES];
   logic signed [W-1:0] box_max [NUM_AXES];

   rbs_box_regs #(.W(W), .F(F)) u_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .box_min (box_min),
      .box_max (box_max)
   );

   // stage valid bits and per-stage advance
   logic [S-1:0] v_ff;
   logic [S-1:0] en;

   always_comb begin
      en[S-1] = !v_ff[S-1] || rsp_ch.ready;
      for (int i = S - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_ch.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_ch.valid;
         for (int i = 1; i < S; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // stage A: plane distances and direction magnitude
   logic signed [W-1:0] o_c [NUM_AXES];
   logic signed [W-1:0] d_c [NUM_AXES];
   assign o_c[0] = req_ch.origin_x;
   assign o_c[1] = req_ch.origin_y;
   assign o_c[2] = req_ch.origin_z;
   assign d_c[0] = req_ch.dir_x;
   assign d_c[1] = req_ch.dir_y;
   assign d_c[2] = req_ch.dir_z;

   logic signed [W:0]   dl_ff [NUM_AXES];
   logic signed [W:0]   dh_ff [NUM_AXES];
   logic [W-1:0]        dm_ff [NUM_AXES];
   logic                dn_ff [NUM_AXES];
   logic [NUM_AXES-1:0] dz_ff [ST_C];
   logic [NUM_AXES-1:0] in_ff [ST_C];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            dl_ff[a]    <= {box_min[a][W-1], box_min[a]} - {o_c[a][W-1], o_c[a]};
            dh_ff[a]    <= {box_max[a][W-1], box_max[a]} - {o_c[a][W-1], o_c[a]};
            dm_ff[a]    <= d_c[a][W-1] ? (~d_c[a] + W'(1)) : d_c[a];
            dn_ff[a]    <= d_c[a][W-1];
            dz_ff[0][a] <= d_c[a] == '0;
            in_ff[0][a] <= (o_c[a] >= box_min[a]) && (o_c[a] <= box_max[a]);
         end
      end
   end

   // zero-direction and inside-slab flags ride along to stage C
   always_ff @(posedge clock) begin
      for (int i = 1; i < ST_C; i++) begin
         if (en[i]) begin
            dz_ff[i] <= dz_ff[i-1];
            in_ff[i] <= in_ff[i-1];
         end
      end
   end

   // stage B: pick near and far planes, magnitude, sign, overflow check
   logic [W:0]   n_ff   [NUM_LANES];
   logic [W-1:0] d_ff   [NUM_LANES];
   logic         neg_ff [NUM_LANES];
   logic         ovf_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            for (int s = 0; s < 2; s++) begin
               logic signed [W:0] num;
               logic [W:0]        nm;
               num = ((s == 0) != dn_ff[a]) ? dl_ff[a] : dh_ff[a];
               nm  = num[W] ? (~num + (W+1)'(1)) : num;
               n_ff[2*a+s]   <= nm;
               d_ff[2*a+s]   <= dm_ff[a];
               neg_ff[2*a+s] <= num[W] != dn_ff[a];
               ovf_ff[2*a+s] <= (2*W)'(nm) >= ((2*W)'(dm_ff[a]) << (W - F));
            end
         end
      end
   end

   // divider pipelines, lane 2a is the near plane and 2a+1 the far plane of axis a
   logic [W-1:0] q_l   [NUM_LANES];
   logic         neg_l [NUM_LANES];
   logic         ovf_l [NUM_LANES];

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      rbs_div_lane #(.W(W), .F(F)) u_div (
         .clock   (clock),
         .en      (en[W+1:2]),
         .n_in    (n_ff[l]),
         .d_in    (d_ff[l]),
         .neg_in  (neg_ff[l]),
         .ovf_in  (ovf_ff[l]),
         .q_out   (q_l[l]),
         .neg_out (neg_l[l]),
         .ovf_out (ovf_l[l])
      );
   end

   // stage C: saturate, apply sign, zero-direction override
   logic signed [W-1:0] t_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (en[ST_C]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            for (int s = 0; s < 2; s++) begin
               logic [W-1:0] lim;
               logic [W-1:0] qs;
               lim = neg_l[2*a+s] ? TMIN : TMAX;
               qs  = (ovf_l[2*a+s] || (q_l[2*a+s] > lim)) ? lim : q_l[2*a+s];
               if (dz_ff[ST_C-1][a]) begin
                  t_ff[2*a+s] <= ((s == 0) == in_ff[ST_C-1][a]) ? TMIN : TMAX;
               end else begin
                  t_ff[2*a+s] <= neg_l[2*a+s] ? (~qs + W'(1)) : qs;
               end
            end
         end
      end
   end

   // stage D: latest entry, earliest exit, hit test
   logic signed [W-1:0] ent_ff;
   logic signed [W-1:0] ext_ff;
   logic                hit_ff;

   always_ff @(posedge clock) begin
      if (en[S-1]) begin
         logic signed [W-1:0] e;
         logic signed [W-1:0] x;
         e = t_ff[0];
         x = t_ff[1];
         for (int a = 1; a < NUM_AXES; a++) begin
            if (t_ff[2*a] > e) e = t_ff[2*a];
            if (t_ff[2*a+1] < x) x = t_ff[2*a+1];
         end
         ent_ff <= e;
         ext_ff <= x;
         hit_ff <= (x > e) && (e > 0);
      end
   end

   assign rsp_ch.valid     = v_ff[S-1];
   assign rsp_ch.hit_found = hit_ff;
   assign rsp_ch.t_enter   = ent_ff;
   assign rsp_ch.t_exit    = ext_ff;

`ifndef SYNTHESIS
   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.hit_found |-> (rsp_ch.t_exit > rsp_ch.t_enter)
         && (rsp_ch.t_enter > 0))
      else $error("hit reported with exit not beyond positive entry");
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v_ff[0])
      else $error("accepted transaction did not enter the pipeline");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v_ff[S-2] && !en[S-2] |=> v_ff[S-2] && v_ff[S-1])
      else $error("stalled stage lost its transaction");
`endif
endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rbs_pkg::*;

   localparam int W          = COORD_WIDTH_DEF;
   localparam int FB         = FRAC_BITS_DEF;
   localparam int ONE        = 1 << FB;
   localparam int LAT        = W + 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD  = 300;

   typedef logic signed [W-1:0] coord_type;

   // origin x,y,z then direction x,y,z
   typedef struct {
      coord_type v[6];
   } ray_type;

   typedef struct {
      logic      hit;
      coord_type t_enter;
      coord_type t_exit;
   } hit_type;

   // slab test predictor with its own copy of the box
   class slab_scoreboard;
      coord_type box[6];
      hit_type   hit_q[$];
      int        errors;

      function new();
         box[0] = '0;
         box[1] = '0;
         box[2] = '0;
         box[3] = coord_type'(ONE);
         box[4] = coord_type'(ONE);
         box[5] = coord_type'(ONE);
         errors = 0;
      endfunction

      // quotient truncated toward zero to FB fraction bits, saturated
      function longint fixed_div(longint num, longint den);
         longint unsigned n, d, qi, r, q, lim;
         bit neg;
         n = (num < 0) ? longint'(-num) : num;
         d = (den < 0) ? longint'(-den) : den;
         neg = (num < 0) != (den < 0);
         if (n == 0) return 0;
         qi = n / d;
         r = n % d;
         lim = neg ? (64'd1 << (W - 1)) : (64'd1 << (W - 1)) - 1;
         if (qi >= (64'd1 << (W - FB))) begin
            q = lim;
         end else begin
            q = qi;
            for (int i = 0; i < FB; i++) begin
               r = r << 1;
               q = q << 1;
               if (r >= d) begin
                  r = r - d;
                  q = q | 1;
               end
            end
            if (q > lim) q = lim;
         end
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function void note_ray(ray_type r);
         longint t_min, t_max, enter, leave, lo, hi, o, d, nr, fr;
         hit_type e;
         t_max = (64'sd1 <<< (W - 1)) - 1;
         t_min = -t_max - 1;
         enter = t_min;
         leave = t_max;
         for (int a = 0; a < 3; a++) begin
            lo = longint'(box[a]);
            hi = longint'(box[a + 3]);
            o  = longint'(r.v[a]);
            d  = longint'(r.v[a + 3]);
            if (d == 0) begin
               // parallel ray: unlimited inside the slab, a miss outside
               if (o >= lo && o <= hi) begin
                  nr = t_min;
                  fr = t_max;
               end else begin
                  nr = t_max;
                  fr = t_min;
               end
            end else if (d > 0) begin
               nr = fixed_div(lo - o, d);
               fr = fixed_div(hi - o, d);
            end else begin
               nr = fixed_div(hi - o, d);
               fr = fixed_div(lo - o, d);
            end
            if (nr > enter) enter = nr;
            if (fr < leave) leave = fr;
         end
         e.hit     = (leave > enter) && (enter > 0);
         e.t_enter = coord_type'(enter);
         e.t_exit  = coord_type'(leave);
         hit_q.push_back(e);
      endfunction

      function void check_hit(hit_type got);
         hit_type e;
         if (hit_q.size() == 0) begin
            $display("%0t: unexpected transaction hit=%0b enter=%0d exit=%0d",
                     $time, got.hit, got.t_enter, got.t_exit);
            errors++;
            return;
         end
         e = hit_q.pop_front();
         if (got.hit !== e.hit) begin
            $display("%0t: hit_found expected %0b actual %0b", $time, e.hit, got.hit);
            errors++;
         end
         if (got.t_enter !== e.t_enter) begin
            $display("%0t: t_enter expected %0d actual %0d", $time, e.t_enter, got.t_enter);
            errors++;
         end
         if (got.t_exit !== e.t_exit) begin
            $display("%0t: t_exit expected %0d actual %0d", $time, e.t_exit, got.t_exit);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles = 0;
   bit   idle_on;
   bit   hold_long;
   slab_scoreboard sb;

   rbs_req_if #(.W(W)) req_ch ();
   rbs_rsp_if #(.W(W)) rsp_ch ();
   rbs_csr_if #(.W(W)) csr_ch ();

   ray_box_slab_intersect uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // accepted ray transactions feed the predictor
   always @(posedge clock) begin
      ray_type r;
      if (!reset && req_ch.valid && req_ch.ready) begin
         r.v[0] = req_ch.origin_x;
         r.v[1] = req_ch.origin_y;
         r.v[2] = req_ch.origin_z;
         r.v[3] = req_ch.dir_x;
         r.v[4] = req_ch.dir_y;
         r.v[5] = req_ch.dir_z;
         sb.note_ray(r);
      end
   end

   // accepted result transactions are checked
   always @(posedge clock) begin
      hit_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.hit     = rsp_ch.hit_found;
         got.t_enter = rsp_ch.t_enter;
         got.t_exit  = rsp_ch.t_exit;
         sb.check_hit(got);
      end
   end

   // result receiver with random stalls and one long hold-off
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         if (hold_long) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic write_reg(csr_index_type idx, coord_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      sb.box[idx] = value;
   endtask

   task automatic set_box(coord_type x0, coord_type y0, coord_type z0,
                          coord_type x1, coord_type y1, coord_type z1);
      write_reg(CSR_MIN_X, x0);
      write_reg(CSR_MIN_Y, y0);
      write_reg(CSR_MIN_Z, z0);
      write_reg(CSR_MAX_X, x1);
      write_reg(CSR_MAX_Y, y1);
      write_reg(CSR_MAX_Z, z1);
   endtask

   // wait until every expected result has come, then let the pipe settle
   task automatic drain();
      while (sb.hit_q.size() != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
   endtask

   task automatic send_ray(coord_type ox, coord_type oy, coord_type oz,
                           coord_type dx, coord_type dy, coord_type dz);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.origin_x <= ox;
      req_ch.origin_y <= oy;
      req_ch.origin_z <= oz;
      req_ch.dir_x    <= dx;
      req_ch.dir_y    <= dy;
      req_ch.dir_z    <= dz;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic coord_type small_coord();
      return coord_type'(int'($urandom_range(0, 8 * ONE)) - 4 * ONE);
   endfunction

   function automatic coord_type any_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'($urandom);
         1: return $urandom_range(0, 1) ? coord_type'({1'b1, {(W-1){1'b0}}})
                                        : coord_type'({1'b0, {(W-1){1'b1}}});
         2: return '0;
         3: return coord_type'(int'($urandom_range(0, 8)) - 4);
         default: return small_coord();
      endcase
   endfunction

   // mostly rays aimed at a point near the box, plus wild rays
   task automatic random_rays(int count);
      coord_type o[3];
      coord_type d[3];
      int sel;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         for (int a = 0; a < 3; a++) begin
            if (sel < 60) begin
               o[a] = small_coord();
               d[a] = coord_type'(int'(sb.box[a]) + int'($urandom_range(0, ONE))
                                  - int'(o[a]));
               if ($urandom_range(0, 9) == 0) d[a] = '0;
            end else if (sel < 85) begin
               o[a] = small_coord();
               d[a] = small_coord();
            end else begin
               o[a] = any_coord();
               d[a] = any_coord();
            end
         end
         send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
      end
   endtask

   // stimulus
   initial begin
      coord_type lo[3];
      coord_type hi[3];
      sb = new();
      idle_on = 1'b1;
      hold_long = 1'b0;
      reset <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.origin_x <= '0;
      req_ch.origin_y <= '0;
      req_ch.origin_z <= '0;
      req_ch.dir_x    <= '0;
      req_ch.dir_y    <= '0;
      req_ch.dir_z    <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_MIN_X;
      csr_ch.data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rays against the unit box left by reset
      send_ray(-ONE, ONE / 2, ONE / 2, ONE, 0, 0);
      send_ray(2 * ONE, ONE / 2, ONE / 2, -ONE, 0, 0);
      send_ray(ONE / 2, ONE / 2, ONE / 2, ONE, ONE, ONE);
      send_ray(ONE / 2, ONE / 2, ONE / 2, 0, 0, 0);
      send_ray(2 * ONE, ONE / 2, ONE / 2, 0, 0, 0);
      send_ray(0, ONE, ONE / 2, 0, 0, ONE);
      send_ray(-ONE, ONE / 2, ONE / 2, 1, 0, 0);
      send_ray(-ONE, ONE / 2, ONE / 2, -1, 0, 0);
      send_ray(-ONE, -ONE, ONE / 2, ONE, ONE, 0);
      send_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE);
      send_ray(-ONE, 2 * ONE, ONE / 2, ONE, -ONE, 0);
      send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 1, 1);
      send_ray(32'sh7fff_ffff, 0, 0, -1, 0, 0);
      send_ray(-1, -1, -1, -1, -1, -1);
      send_ray(-ONE, ONE / 2, ONE / 2, 3 * ONE, 0, 0);
      send_ray(-ONE, -ONE / 3, ONE / 2, 7, 5, 0);
      send_ray(0, 0, 0, 0, 0, 0);
      send_ray(-ONE, 0, 0, ONE, 0, 0);
      req_ch.valid <= 1'b0;
      drain();

      // widest box at the range limits, receiver hold-off fills the pipe
      set_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      hold_long = 1'b1;
      random_rays(200);
      req_ch.valid <= 1'b0;
      drain();

      // inverted box
      set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
      random_rays(150);
      req_ch.valid <= 1'b0;
      drain();

      // random small boxes; the last phase runs without idling
      for (int p = 0; p < 7; p++) begin
         for (int a = 0; a < 3; a++) begin
            lo[a] = small_coord();
            hi[a] = coord_type'(int'(lo[a]) + int'($urandom_range(0, 3 * ONE)));
         end
         set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
         if (p == 6) idle_on = 1'b0;
         random_rays(190);
         req_ch.valid <= 1'b0;
         drain();
      end

      if (sb.errors == 0 && sb.hit_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
